// ----- hw/rtl/hsfc_pkg.sv -----
// Package for the half/single float converter.
// Field widths, format constants and operation codes; no dependencies.
package hsfc_pkg;
    localparam int SGL_MANT_W = 23;
    localparam int SGL_EXP_W  = 8;
    localparam int HLF_MANT_W = 10;
    localparam int HLF_EXP_W  = 5;
    localparam int DATA_W     = 32;
    localparam int MANT_SHIFT = SGL_MANT_W - HLF_MANT_W;

    typedef enum logic [0:0] {
        OP_H2S = 1'b0,
        OP_S2H = 1'b1
    } op_t;
endpackage

// ----- hw/rtl/hsfc_h2s.sv -----
// Binary16 to binary32 conversion, combinational and exact.
// Depends on hsfc_pkg.
module hsfc_h2s import hsfc_pkg::*; (
    input  logic [15:0]       half_in,
    output logic [DATA_W-1:0] single_out
);
    logic       sgn;
    logic [4:0] hexp;
    logic [9:0] hman;
    logic [3:0] lz;
    logic [9:0] nman;
    logic [7:0] sexp;

    // leading-zero count of the subnormal mantissa
    always_comb begin
        lz = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (hman[i]) lz = 4'(9 - i);
        end
    end

    always_comb begin
        sgn  = half_in[15];
        hexp = half_in[14:10];
        hman = half_in[9:0];
        nman = 10'(hman << (lz + 4'd1));
        sexp = 8'(hexp) + 8'd112;
        if (hexp == 5'd0) begin
            if (hman == 10'd0) single_out = {sgn, 31'd0};
            else single_out = {sgn, 8'(8'd113 - 8'(lz) - 8'd1), nman, 13'd0};
        end else if (hexp == 5'h1F) begin
            single_out = {sgn, 8'hFF, hman, 13'd0};
        end else begin
            single_out = {sgn, sexp, hman, 13'd0};
        end
    end
endmodule

// ----- hw/rtl/hsfc_s2h.sv -----
// Binary32 to binary16 conversion, round to nearest even.
// Depends on hsfc_pkg.
module hsfc_s2h import hsfc_pkg::*; (
    input  logic [DATA_W-1:0] single_in,
    output logic [15:0]       half_out
);
    logic        sgn;
    logic [7:0]  sexp;
    logic [22:0] sman;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [47:0] wide;
    logic [23:0] rem;
    logic [23:0] halfway;
    logic [14:0] mag;
    logic [14:0] nmag;
    logic [12:0] nrem;

    always_comb begin
        sgn  = single_in[31];
        sexp = single_in[30:23];
        sman = single_in[22:0];
        sig  = {1'b1, sman};
        sh   = 5'(8'd126 - sexp);
        wide = {sig, 24'd0} >> sh;
        rem  = wide[23:0];
        halfway = 24'h800000;
        nrem = sman[12:0];
        nmag = {5'(sexp - 8'd112), sman[22:13]};
        mag  = 15'd0;
        if (sexp == 8'hFF) begin
            mag = (sman != 23'd0) ? 15'h7E00 : 15'h7C00;
        end else if (sexp >= 8'd143) begin
            mag = 15'h7C00;
        end else if (sexp > 8'd112) begin
            mag = nmag;
            if (nrem > 13'h1000 || (nrem == 13'h1000 && nmag[0])) mag = nmag + 15'd1;
        end else if (sexp < 8'd102) begin
            mag = 15'd0;
        end else begin
            // subnormal: remainder aligned so halfway sits at bit 23
            mag = 15'(wide[47:24]);
            if (rem > halfway || (rem == halfway && wide[24])) mag = mag + 15'd1;
        end
        half_out = {sgn, mag};
    end
endmodule

// ----- hw/rtl/half_single_float_converter.sv -----
// Half/single float converter top level: input register, conversion logic, output register.
// Throughput one item per cycle while the receiver keeps m_tready high.
// Input register and output register each hold one item; s_tready is high when the
// input stage is empty or the output stage can load. Reset (aresetn low, synchronous)
// empties both stages; data registers are not reset. Depends on hsfc_pkg, hsfc_h2s, hsfc_s2h.
module half_single_float_converter import hsfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // source_bits[31:0]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result_bits[31:0]
);
    logic              in_vld_reg;
    logic              in_op_reg;
    logic [DATA_W-1:0] in_dat_reg;
    logic              out_vld_reg;
    logic [DATA_W-1:0] out_dat_reg;
    logic [DATA_W-1:0] h2s_res;
    logic [15:0]       s2h_res;
    logic              out_load;

    hsfc_h2s u_h2s (.half_in(in_dat_reg[15:0]), .single_out(h2s_res));
    hsfc_s2h u_s2h (.single_in(in_dat_reg), .half_out(s2h_res));

    assign out_load = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || out_load;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg  <= s_tuser;
            in_dat_reg <= s_tdata;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= in_vld_reg;
        end
        if (out_load && in_vld_reg) begin
            out_dat_reg <= (in_op_reg == OP_S2H) ? {16'd0, s2h_res} : h2s_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_tready |=> out_vld_reg && $stable(out_dat_reg))
        else $error("result changed while stalled");
    a_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_load |=> out_vld_reg)
        else $error("item lost between stages");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("empty input stage not ready");
endmodule

// ----- verif/half_single_float_converter_checker.sv -----
// Checker for the half/single float converter: watches both stream channels,
// predicts each result from the accepted input and compares in order.
// Depends on hsfc_pkg.
module half_single_float_converter_checker import hsfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    logic [31:0] converted_q[$];

    // exact widening of a binary16 pattern
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [10:0] norm;
        logic [7:0]  se;
        sgn  = h[15];
        ex   = h[14:10];
        man  = h[9:0];
        if (ex == 5'd0) begin
            if (man == 10'd0)
                return {sgn, 31'd0};
            norm = {1'b0, man};
            se   = 8'd113;
            while (!norm[10]) begin
                norm = norm << 1;
                se   = se - 8'd1;
            end
            return {sgn, se, norm[9:0], 13'd0};
        end
        if (ex == 5'h1F)
            return {sgn, 8'hFF, man, 13'd0};
        return {sgn, 8'(ex) + 8'd112, man, 13'd0};
    endfunction

    // binary32 to binary16, round to nearest even
    function automatic logic [15:0] narrow_single(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  ex;
        logic [22:0] man;
        logic [31:0] mag, rem, halfway, sig;
        int          sh;
        sgn = x[31];
        ex  = x[30:23];
        man = x[22:0];
        if (ex == 8'hFF) begin
            mag = (man != 0) ? 32'h7E00 : 32'h7C00;
        end else if (ex >= 8'd143) begin
            mag = 32'h7C00;
        end else if (ex > 8'd112) begin
            rem = {19'd0, man[12:0]};
            mag = ((32'(ex) - 32'd112) << 10) | 32'(man[22:13]);
            if (rem > 32'h1000 || (rem == 32'h1000 && mag[0]))
                mag = mag + 1;
            if (mag > 32'h7C00)
                mag = 32'h7C00;
        end else if (ex < 8'd102) begin
            mag = 0;
        end else begin
            sig     = {9'd1, man};
            sh      = 126 - int'(ex);
            rem     = sig & ((32'd1 << sh) - 1);
            halfway = 32'd1 << (sh - 1);
            mag     = sig >> sh;
            if (rem > halfway || (rem == halfway && mag[0]))
                mag = mag + 1;
        end
        return {sgn, mag[14:0]};
    endfunction

    assign pending_count = converted_q.size();

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            fail_count   <= 0;
            result_count <= 0;
            converted_q.delete();
        end else begin
            // input transaction: queue the predicted result
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_H2S)
                    converted_q.push_back(widen_half(s_tdata[15:0]));
                else
                    converted_q.push_back({16'd0, narrow_single(s_tdata)});
            end
            // result transaction: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (converted_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = converted_q.pop_front();
                    if (want !== m_tdata) begin
                        if (fail_count < 10)
                            $display("result_bits: expected %h got %h", want, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- verif/half_single_float_converter_tb.sv -----
// Testbench top for the half/single float converter: clock, reset, stimulus
// with bursty sender and stalling receiver, verdict. Depends on hsfc_pkg,
// the converter RTL and half_single_float_converter_checker.
module half_single_float_converter_tb import hsfc_pkg::*;;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count, pending_count, result_count;
    int          cycle_count = 0;
    int          stall_mode = 0;

    localparam int CYCLE_LIMIT = 200000;

    always #5 aclk = ~aclk;

    half_single_float_converter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    half_single_float_converter_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // receiver stall pattern: phases of always-ready, random, and heavy stall
    always @(posedge aclk) begin
        if (cycle_count % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("half_single_float_converter: mismatch");
            $finish;
        end
    end

    // one transaction; valid stays high across back-to-back items
    task automatic send_item(input op_t op, input logic [31:0] bits, input bit keep);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= bits;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!keep)
            s_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] random_source(output op_t op);
        int pick;
        logic [31:0] v;
        op   = op_t'($urandom_range(0, 1));
        v    = $urandom;
        pick = $urandom_range(0, 7);
        if (op == OP_S2H) begin
            // steer exponents toward the interesting bands, or force a rounding tie
            case (pick)
                0: v[30:23] = 8'($urandom_range(100, 114));
                1: v[30:23] = 8'($urandom_range(140, 144));
                2: v[30:23] = 8'hFF;
                3: v[12:0]  = 13'h1000;
                4: v[30:23] = 8'($urandom_range(113, 142));
                default: ;
            endcase
        end else begin
            if (pick == 0) v[14:10] = 5'd0;
            if (pick == 1) v[14:10] = 5'h1F;
        end
        return v;
    endfunction

    initial begin
        logic [31:0] directed_s2h[$];
        logic [31:0] directed_h2s[$];
        logic [31:0] bits;
        op_t         op;
        int          burst, gap, n, drain;

        directed_h2s = '{32'h0000, 32'h8000, 32'h0001, 32'h83FF, 32'h7C00, 32'hFC00,
                         32'h7C01, 32'hFE00, 32'h7BFF, 32'hFFFF_3C00, 32'hABCD_0400};
        directed_s2h = '{32'h0000_0000, 32'h8000_0001, 32'h7F80_0000, 32'hFF80_0000,
                         32'h7F80_0001, 32'hFFC0_0000, 32'h477F_E000, 32'h477F_F000,
                         32'h4780_0000, 32'h387F_E000, 32'h3380_0000, 32'h3300_0001,
                         32'h3300_0000, 32'h3F80_1000, 32'h3F80_3000};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, specials, rounding edges
        foreach (directed_h2s[i]) send_item(OP_H2S, directed_h2s[i], 1'b1);
        foreach (directed_s2h[i])
            send_item(OP_S2H, directed_s2h[i], i != directed_s2h.size() - 1);

        // hold off until every expected result has come back
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);

        // random bursts; a burst followed by no gap keeps valid high
        n = 0;
        while (n < 700) begin
            burst = $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < burst; k++) begin
                bits = random_source(op);
                send_item(op, bits, (k != burst - 1) || (gap == 0 && n < 699));
                n++;
            end
            repeat (gap) @(posedge aclk);
        end

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        drain = 0;
        while (drain < 10) begin
            @(posedge aclk);
            drain++;
        end
        $display("Covered %0d results: both directions, subnormals, NaN/Inf, overflow,",
                 result_count);
        $display("tie rounding, under bursty input and stalled output.");
        if (fail_count == 0)
            $display("half_single_float_converter: match");
        else
            $display("half_single_float_converter: mismatch");
        $finish;
    end
endmodule
